@@ rtl/aae_pkg.sv @@
// shared types and constants of the adaptive arithmetic encoder
`default_nettype none
package aae_pkg;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    localparam logic [31:0] MIN_LEN    = 32'h0100_0000;
    localparam logic [31:0] FULL_LEN   = 32'hFFFF_FFFF;
    localparam logic [31:0] SCALE_NUM  = 32'h8000_0000;
    localparam logic [15:0] FREQ_LIMIT = 16'h8000;
    localparam logic [24:0] BYTE_CAP   = 25'h100_0000;

    // result queue holds the bytes of one request
    localparam int QDEPTH = 64;
    localparam int QAW    = 6;
    localparam int QCW    = 7;

    // alphabet arithmetic is 12 bits wide
    localparam int NW = 12;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INIT,
        ST_RB_ADD,
        ST_HV_RD,
        ST_HV_WR,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_CM_RD,
        ST_CM_MUL,
        ST_CM_WR,
        ST_RB_END,
        ST_ENC_RD,
        ST_ENC_MUL,
        ST_ENC_ADD,
        ST_FLUSH,
        ST_POST,
        ST_REN,
        ST_DRAIN,
        ST_ENC_CNT,
        ST_FL_REL,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT
    } aae_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } aae_div_stat_t;

endpackage
`default_nettype wire

@@ rtl/aae_div.sv @@
// restoring divider, one quotient bit per cycle
`default_nettype none
module aae_div
    import aae_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [31:0]   dividend,
    input  wire logic [15:0]   divisor,
    output aae_div_stat_t      stat,
    output logic [31:0]        quotient
);

    logic [31:0] dvd_reg, dvd_next;
    logic [31:0] quo_reg, quo_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [16:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    always_comb begin
        logic [16:0] trial;
        trial     = {rem_reg[15:0], dvd_reg[31]};
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[30:0], 1'b0};
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule
`default_nettype wire

@@ rtl/aae_outq.sv @@
// result byte queue of one request
`default_nettype none
module aae_outq
    import aae_pkg::*;
(
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           clr,
    input  wire logic           wr_en,
    input  wire logic [7:0]     wr_data,
    input  wire logic [QAW-1:0] rd_idx,
    output logic [7:0]          rd_data,
    output logic [QCW-1:0]      count
);

    logic [7:0]     mem [QDEPTH];
    logic [QCW-1:0] count_reg, count_next;
    logic           do_wr;

    // bytes beyond the queue depth are dropped
    assign do_wr = wr_en && (count_reg < QCW'(QDEPTH));

    always_comb begin
        count_next = count_reg;
        if (clr) begin
            count_next = '0;
        end else if (do_wr) begin
            count_next = count_reg + QCW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr && !clr) begin
            mem[count_reg[QAW-1:0]] <= wr_data;
        end
        rd_data <= mem[rd_idx];
    end

    assign count = count_reg;

endmodule
`default_nettype wire

@@ rtl/adaptive_arith_encoder.sv @@
// top level of the adaptive multi-symbol arithmetic encoder
//
//  channel | direction | ports                                              | notes
//  --------+-----------+----------------------------------------------------+---------------------
//  s_      | in        | s_valid s_ready s_opcode s_symbol                  | one request at a time
//  m_      | out       | m_valid m_ready m_code_byte m_byte_valid m_last    | one or more results
//          |           | m_total_bytes m_pending_overflow                   | per request
//  cfg_    | in        | cfg_we cfg_wdata                                   | alphabet size
//
//  encode: symbol lookup, multiply and base update, then renormalization byte by byte,
//    with a closing step after each release of held bytes and a step to end renormalization
//    short of three bytes, then a read, load and handshake per result; a model rebuild
//    runs a 32-step divider and a cumulative table sweep over cnt memory, after a
//    halving pass when counts are halved; start: count fill, then a rebuild
//  results of a request are gathered in a queue and released after it ends,
//    so the error flag they carry is the one after the request
//  reset clears the state, coder and status registers; the model memories are undefined until start
//  s_ready is low from acceptance until the last result is taken
`default_nettype none
module adaptive_arith_encoder
    import aae_pkg::*;
#(
    parameter int MAX_SYMBOLS = 256,
    parameter int MAX_PENDING = 32
)
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [8:0]  cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_opcode,
    input  wire logic [7:0]  s_symbol,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_code_byte,
    output logic             m_byte_valid,
    output logic             m_last,
    output logic [24:0]      m_total_bytes,
    output logic             m_pending_overflow
);

    localparam int AW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int RW = $clog2(MAX_PENDING + 1);

    // model memories
    logic [15:0] cnt_mem [MAX_SYMBOLS];
    logic [15:0] cum_mem [MAX_SYMBOLS];

    logic          cnt_we;
    logic [AW-1:0] cnt_waddr, cnt_raddr;
    logic [15:0]   cnt_wdata, cnt_rdata;
    logic          cum_we;
    logic [AW-1:0] cum_waddr, cum_raddr0, cum_raddr1;
    logic [15:0]   cum_wdata, cum_rdata0, cum_rdata1;

    // control and datapath registers
    aae_state_t    state_reg, state_next;
    aae_state_t    dr_ret_reg, dr_ret_next;
    logic [1:0]    op_reg, op_next;
    logic [AW-1:0] sym_reg, sym_next;
    logic          slast_reg, slast_next;
    logic [8:0]    alpha_reg, alpha_next;
    logic [31:0]   base_reg, base_next;
    logic [31:0]   len_reg, len_next;
    logic [15:0]   ct_reg, ct_next;
    logic [11:0]   period_reg, period_next;
    logic [11:0]   until_reg, until_next;
    logic [7:0]    held_reg, held_next;
    logic          hvld_reg, hvld_next;
    logic [RW-1:0] run_reg, run_next;
    logic [24:0]   bytes_reg, bytes_next;
    logic          err_reg, err_next;
    logic [AW-1:0] k_reg, k_next;
    logic [31:0]   acc_reg, acc_next;
    logic [31:0]   scale_reg, scale_next;
    logic [31:0]   prod_reg, prod_next;
    logic [31:0]   plo_reg, plo_next;
    logic [31:0]   phi_reg, phi_next;
    logic [1:0]    ren_reg, ren_next;
    logic          dr_fv_reg, dr_fv_next;
    logic [7:0]    dr_first_reg, dr_first_next;
    logic [7:0]    dr_fill_reg, dr_fill_next;
    logic [RW-1:0] dr_cnt_reg, dr_cnt_next;
    logic [QAW-1:0] oidx_reg, oidx_next;
    logic          mv_reg, mv_next;
    logic [7:0]    mbyte_reg, mbyte_next;
    logic          mbv_reg, mbv_next;
    logic          mlast_reg, mlast_next;
    logic [24:0]   mtot_reg, mtot_next;
    logic          merr_reg, merr_next;

    // result queue and divider hookup
    logic           q_clr, q_wr;
    logic [7:0]     q_wdata, q_rdata;
    logic [QCW-1:0] q_count;
    logic           div_start;
    aae_div_stat_t  div_stat;
    logic [31:0]    div_q;

    // effective alphabet, clamped to the supported range
    logic [NW-1:0]  n_eff;
    logic [AW-1:0]  n_last;

    always_comb begin
        if ({3'b0, alpha_reg} < NW'(2)) begin
            n_eff = NW'(2);
        end else if ({3'b0, alpha_reg} > NW'(MAX_SYMBOLS)) begin
            n_eff = NW'(MAX_SYMBOLS);
        end else begin
            n_eff = {3'b0, alpha_reg};
        end
    end
    assign n_last = AW'(n_eff - NW'(1));

    aae_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (q_clr),
        .wr_en   (q_wr),
        .wr_data (q_wdata),
        .rd_idx  (oidx_reg),
        .rd_data (q_rdata),
        .count   (q_count)
    );

    aae_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (SCALE_NUM),
        .divisor  (ct_reg),
        .stat     (div_stat),
        .quotient (div_q)
    );

    always_comb begin
        logic [NW-1:0] sym_wide;
        logic [31:0]   nb;
        logic [16:0]   unit;
        logic [32:0]   mlo, mhi;
        logic [16:0]   half;
        logic [15:0]   ct_sum;
        logic [14:0]   p5;
        logic [NW-1:0] n6;
        logic [11:0]   cap, np;
        logic [7:0]    rb;
        logic          carry;
        logic          ren_go;

        state_next    = state_reg;
        dr_ret_next   = dr_ret_reg;
        op_next       = op_reg;
        sym_next      = sym_reg;
        slast_next    = slast_reg;
        alpha_next    = alpha_reg;
        base_next     = base_reg;
        len_next      = len_reg;
        ct_next       = ct_reg;
        period_next   = period_reg;
        until_next    = until_reg;
        held_next     = held_reg;
        hvld_next     = hvld_reg;
        run_next      = run_reg;
        bytes_next    = bytes_reg;
        err_next      = err_reg;
        k_next        = k_reg;
        acc_next      = acc_reg;
        scale_next    = scale_reg;
        prod_next     = prod_reg;
        plo_next      = plo_reg;
        phi_next      = phi_reg;
        ren_next      = ren_reg;
        dr_fv_next    = dr_fv_reg;
        dr_first_next = dr_first_reg;
        dr_fill_next  = dr_fill_reg;
        dr_cnt_next   = dr_cnt_reg;
        oidx_next     = oidx_reg;
        mv_next       = mv_reg;
        mbyte_next    = mbyte_reg;
        mbv_next      = mbv_reg;
        mlast_next    = mlast_reg;
        mtot_next     = mtot_reg;
        merr_next     = merr_reg;

        cnt_we     = 1'b0;
        cnt_waddr  = k_reg;
        cnt_wdata  = 16'd1;
        cnt_raddr  = k_reg;
        cum_we     = 1'b0;
        cum_waddr  = k_reg;
        cum_wdata  = prod_reg[31:16];
        cum_raddr0 = sym_reg;
        cum_raddr1 = slast_reg ? sym_reg : sym_reg + AW'(1);
        q_clr      = 1'b0;
        q_wr       = 1'b0;
        q_wdata    = dr_fill_reg;
        div_start  = 1'b0;

        sym_wide = {4'b0, s_symbol};
        unit     = len_reg[31:15];
        mlo      = {17'b0, cum_rdata0} * {16'b0, unit};
        mhi      = {17'b0, cum_rdata1} * {16'b0, unit};
        half     = ({1'b0, cnt_rdata} + 17'd1) >> 1;
        ct_sum   = ct_reg + {4'b0, period_reg};
        p5       = {1'b0, period_reg, 2'b00} + {3'b0, period_reg};
        n6       = n_eff + NW'(6);
        cap      = {n6[8:0], 3'b000};
        np       = (p5[13:2] > cap) ? cap : p5[13:2];
        rb       = base_reg[31:24];
        nb       = base_reg;
        carry    = 1'b0;
        ren_go   = (ren_reg == 2'd0) || ((len_reg < MIN_LEN) && (ren_reg != 2'd3));

        // alphabet register, written whenever cfg_we is high
        if (cfg_we) begin
            alpha_next = cfg_wdata;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next   = s_opcode;
                    oidx_next = '0;
                    q_clr     = 1'b1;
                    if (sym_wide >= n_eff) begin
                        sym_next   = n_last;
                        slast_next = 1'b1;
                    end else begin
                        sym_next   = AW'(sym_wide);
                        slast_next = (AW'(sym_wide) == n_last);
                    end
                    priority case (s_opcode)
                        OP_START: begin
                            base_next   = '0;
                            len_next    = FULL_LEN;
                            held_next   = '0;
                            hvld_next   = 1'b0;
                            run_next    = '0;
                            bytes_next  = '0;
                            err_next    = 1'b0;
                            ct_next     = '0;
                            period_next = n_eff;
                            k_next      = '0;
                            state_next  = ST_INIT;
                        end
                        OP_ENCODE: state_next = ST_ENC_RD;
                        OP_FLUSH:  state_next = ST_FLUSH;
                        default:   state_next = ST_OUT_RD;
                    endcase
                end
            end
            // every count of the alphabet starts at one
            ST_INIT: begin
                cnt_we = 1'b1;
                if (k_reg == n_last) begin
                    state_next = ST_RB_ADD;
                end else begin
                    k_next = k_reg + AW'(1);
                end
            end
            ST_RB_ADD: begin
                k_next = '0;
                if (ct_sum > FREQ_LIMIT) begin
                    ct_next    = '0;
                    state_next = ST_HV_RD;
                end else begin
                    ct_next    = ct_sum;
                    state_next = ST_DIV_GO;
                end
            end
            ST_HV_RD: state_next = ST_HV_WR;
            // halve each count, rounding up, and sum them again
            ST_HV_WR: begin
                cnt_we    = 1'b1;
                cnt_wdata = half[15:0];
                ct_next   = ct_reg + half[15:0];
                if (k_reg == n_last) begin
                    state_next = ST_DIV_GO;
                end else begin
                    k_next     = k_reg + AW'(1);
                    state_next = ST_HV_RD;
                end
            end
            ST_DIV_GO: begin
                k_next   = '0;
                acc_next = '0;
                if (ct_reg == 16'd0) begin
                    scale_next = FULL_LEN;
                    state_next = ST_CM_RD;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (div_stat.done) begin
                    scale_next = div_q;
                    state_next = ST_CM_RD;
                end
            end
            ST_CM_RD: state_next = ST_CM_MUL;
            ST_CM_MUL: begin
                prod_next  = scale_reg * acc_reg;
                acc_next   = acc_reg + {16'b0, cnt_rdata};
                state_next = ST_CM_WR;
            end
            ST_CM_WR: begin
                cum_we = 1'b1;
                if (k_reg == n_last) begin
                    state_next = ST_RB_END;
                end else begin
                    k_next     = k_reg + AW'(1);
                    state_next = ST_CM_RD;
                end
            end
            // period grows by 5/4 up to its cap; a start sets its own period
            ST_RB_END: begin
                if (op_reg == OP_START) begin
                    period_next = {1'b0, n6[11:1]};
                    until_next  = {1'b0, n6[11:1]};
                end else begin
                    period_next = np;
                    until_next  = np;
                end
                state_next = ST_OUT_RD;
            end
            ST_ENC_RD: begin
                cnt_raddr  = sym_reg;
                state_next = ST_ENC_MUL;
            end
            ST_ENC_MUL: begin
                cnt_we     = 1'b1;
                cnt_waddr  = sym_reg;
                cnt_wdata  = cnt_rdata + 16'd1;
                plo_next   = mlo[31:0];
                phi_next   = mhi[31:0];
                state_next = ST_ENC_ADD;
            end
            ST_ENC_ADD, ST_FLUSH: begin
                if (state_reg == ST_ENC_ADD) begin
                    nb       = base_reg + plo_reg;
                    len_next = slast_reg ? (len_reg - plo_reg) : (phi_reg - plo_reg);
                end else if (len_reg > {MIN_LEN[30:0], 1'b0}) begin
                    nb       = base_reg + MIN_LEN;
                    len_next = {1'b0, MIN_LEN[31:1]};
                end else begin
                    nb       = base_reg + {1'b0, MIN_LEN[31:1]};
                    len_next = {9'b0, MIN_LEN[31:9]};
                end
                base_next  = nb;
                carry      = nb < base_reg;
                state_next = ST_POST;
                // carry into held byte; a pending run rolls over to zeros
                if (carry) begin
                    if (run_reg != '0) begin
                        dr_fv_next    = hvld_reg;
                        dr_first_next = held_reg + 8'd1;
                        dr_fill_next  = 8'h00;
                        dr_cnt_next   = run_reg - RW'(1);
                        dr_ret_next   = ST_POST;
                        held_next     = 8'h00;
                        hvld_next     = 1'b1;
                        run_next      = '0;
                        state_next    = ST_DRAIN;
                    end else if (hvld_reg) begin
                        held_next = held_reg + 8'd1;
                    end
                end
            end
            ST_POST: begin
                ren_next = '0;
                if ((op_reg == OP_FLUSH) || (len_reg < MIN_LEN)) begin
                    state_next = ST_REN;
                end else begin
                    state_next = ST_ENC_CNT;
                end
            end
            // byte-wise renormalization, at most three bytes
            ST_REN: begin
                if (!ren_go) begin
                    state_next = (op_reg == OP_FLUSH) ? ST_FL_REL : ST_ENC_CNT;
                end else begin
                    base_next = {base_reg[23:0], 8'h00};
                    len_next  = {len_reg[23:0], 8'h00};
                    ren_next  = ren_reg + 2'd1;
                    if ((rb == 8'hFF) && (run_reg < RW'(MAX_PENDING))) begin
                        run_next = run_reg + RW'(1);
                    end else begin
                        if (rb == 8'hFF) begin
                            err_next = 1'b1;
                        end
                        dr_fv_next    = hvld_reg;
                        dr_first_next = held_reg;
                        dr_fill_next  = 8'hFF;
                        dr_cnt_next   = run_reg;
                        dr_ret_next   = ST_REN;
                        held_next     = rb;
                        hvld_next     = 1'b1;
                        run_next      = '0;
                        state_next    = ST_DRAIN;
                    end
                end
            end
            // emit first byte if any, then the fill run
            ST_DRAIN: begin
                if (dr_fv_reg) begin
                    q_wr       = 1'b1;
                    q_wdata    = dr_first_reg;
                    dr_fv_next = 1'b0;
                end else if (dr_cnt_reg != '0) begin
                    q_wr        = 1'b1;
                    dr_cnt_next = dr_cnt_reg - RW'(1);
                end else begin
                    state_next = dr_ret_reg;
                end
                if (q_wr && (bytes_reg < BYTE_CAP)) begin
                    bytes_next = bytes_reg + 25'd1;
                end
            end
            ST_ENC_CNT: begin
                until_next = until_reg - 12'd1;
                state_next = (until_reg == 12'd1) ? ST_RB_ADD : ST_OUT_RD;
            end
            ST_FL_REL: begin
                dr_fv_next    = hvld_reg;
                dr_first_next = held_reg;
                dr_fill_next  = 8'hFF;
                dr_cnt_next   = run_reg;
                dr_ret_next   = ST_OUT_RD;
                hvld_next     = 1'b0;
                run_next      = '0;
                state_next    = ST_DRAIN;
            end
            // no bytes queued means one bare acknowledgement
            ST_OUT_RD: begin
                if (q_count == '0) begin
                    mv_next    = 1'b1;
                    mbyte_next = 8'h00;
                    mbv_next   = 1'b0;
                    mlast_next = 1'b1;
                    mtot_next  = (op_reg == OP_FLUSH) ? bytes_reg : 25'd0;
                    merr_next  = err_reg;
                    state_next = ST_OUT_WAIT;
                end else begin
                    state_next = ST_OUT_LD;
                end
            end
            ST_OUT_LD: begin
                mv_next    = 1'b1;
                mbyte_next = q_rdata;
                mbv_next   = 1'b1;
                mlast_next = ({1'b0, oidx_reg} == (q_count - QCW'(1)));
                mtot_next  = ((op_reg == OP_FLUSH) &&
                              ({1'b0, oidx_reg} == (q_count - QCW'(1)))) ? bytes_reg : 25'd0;
                merr_next  = err_reg;
                state_next = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                if (m_ready) begin
                    mv_next = 1'b0;
                    if (mlast_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        oidx_next  = oidx_reg + QAW'(1);
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            dr_ret_reg <= ST_IDLE;
            alpha_reg  <= 9'd256;
            base_reg   <= '0;
            len_reg    <= FULL_LEN;
            ct_reg     <= '0;
            period_reg <= '0;
            until_reg  <= '0;
            held_reg   <= '0;
            hvld_reg   <= 1'b0;
            run_reg    <= '0;
            bytes_reg  <= '0;
            err_reg    <= 1'b0;
            mv_reg     <= 1'b0;
            dr_fv_reg  <= 1'b0;
            dr_cnt_reg <= '0;
        end else begin
            state_reg  <= state_next;
            dr_ret_reg <= dr_ret_next;
            alpha_reg  <= alpha_next;
            base_reg   <= base_next;
            len_reg    <= len_next;
            ct_reg     <= ct_next;
            period_reg <= period_next;
            until_reg  <= until_next;
            held_reg   <= held_next;
            hvld_reg   <= hvld_next;
            run_reg    <= run_next;
            bytes_reg  <= bytes_next;
            err_reg    <= err_next;
            mv_reg     <= mv_next;
            dr_fv_reg  <= dr_fv_next;
            dr_cnt_reg <= dr_cnt_next;
        end
        op_reg       <= op_next;
        sym_reg      <= sym_next;
        slast_reg    <= slast_next;
        k_reg        <= k_next;
        acc_reg      <= acc_next;
        scale_reg    <= scale_next;
        prod_reg     <= prod_next;
        plo_reg      <= plo_next;
        phi_reg      <= phi_next;
        ren_reg      <= ren_next;
        dr_first_reg <= dr_first_next;
        dr_fill_reg  <= dr_fill_next;
        oidx_reg     <= oidx_next;
        mbyte_reg    <= mbyte_next;
        mbv_reg      <= mbv_next;
        mlast_reg    <= mlast_next;
        mtot_reg     <= mtot_next;
        merr_reg     <= merr_next;
    end

    // count memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rdata <= cnt_mem[cnt_raddr];
    end

    // cumulative table, one write and two registered read ports
    always_ff @(posedge aclk) begin
        if (cum_we) begin
            cum_mem[cum_waddr] <= cum_wdata;
        end
        cum_rdata0 <= cum_mem[cum_raddr0];
        cum_rdata1 <= cum_mem[cum_raddr1];
    end

    assign s_ready            = (state_reg == ST_IDLE);
    assign m_valid            = mv_reg;
    assign m_code_byte        = mbyte_reg;
    assign m_byte_valid       = mbv_reg;
    assign m_last             = mlast_reg;
    assign m_total_bytes      = mtot_reg;
    assign m_pending_overflow = merr_reg;

    // no request taken while a result is offered
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request accepted while result pending");

    // pending run stays within its bound
    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg <= RW'(MAX_PENDING))
        else $error("pending run above bound");

    // an accepted request leaves s_ready low once it is registered
    a_busy_after: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input reopened too early");

    // the divider is running or finishing while the rebuild waits on it
    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV_WAIT) |-> (div_stat.busy || div_stat.done))
        else $error("waiting on an idle divider");

    // queue never overfills
    a_q_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= QCW'(QDEPTH))
        else $error("result queue overfilled");

endmodule
`default_nettype wire
